FILE: src/hjc_pkg.sv
// Shared types, constants and jamo lookup functions for the Hangul jamo composer.
// No dependencies; hangul_jamo_composer and hjc_step import this package.
package hjc_pkg;

  localparam logic [20:0] JAMO_ORIGIN = 21'h003130;
  localparam logic [20:0] JAMO_FIRST  = 21'h003131;
  localparam logic [20:0] JAMO_LAST   = 21'h003163;
  localparam logic [5:0]  CONS_LAST   = 6'd30;
  localparam logic [5:0]  VOWEL_FIRST = 6'd31;
  localparam logic [5:0]  VOWEL_LAST  = 6'd51;
  localparam logic [15:0] SYL_BASE    = 16'hAC00;
  localparam int          VOWEL_COUNT = 21;
  localparam int          TAIL_COUNT  = 28;

  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Composition state: jamo offsets from U+3130, zero when empty.
  typedef struct packed {
    logic [5:0] lead;
    logic [5:0] vowel;
    logic [5:0] tail;
    logic       composing;
  } hjc_state_t;

  typedef struct packed {
    logic        replace_previous;
    logic [1:0]  char_count;
    logic [20:0] first_char;
    logic [15:0] second_char;
  } hjc_result_t;

  // Consonant offset usable as a lead (the 19 initial consonants).
  function automatic logic lead_ok(logic [5:0] off);
    logic ok;
    case (off) inside
      6'd1, 6'd2, 6'd4, 6'd7, 6'd8, 6'd9, [6'd17:6'd19], [6'd21:6'd30]: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [4:0] lead_index(logic [5:0] off);
    logic [4:0] idx;
    case (off) inside
      6'd1:          idx = 5'd0;
      6'd2:          idx = 5'd1;
      6'd4:          idx = 5'd2;
      6'd7:          idx = 5'd3;
      6'd8:          idx = 5'd4;
      6'd9:          idx = 5'd5;
      6'd17:         idx = 5'd6;
      6'd18:         idx = 5'd7;
      6'd19:         idx = 5'd8;
      [6'd21:6'd30]: idx = 5'(off - 6'd12);
      default:       idx = 5'd0;
    endcase
    return idx;
  endfunction

  function automatic logic tail_ok(logic [5:0] off);
    return (off >= 6'd1) && (off <= CONS_LAST);
  endfunction

  // Tail index; doubled letters other than kk and ss fold onto their base form.
  function automatic logic [4:0] tail_index(logic [5:0] off);
    logic [4:0] idx;
    case (off) inside
      [6'd1:6'd7]:   idx = 5'(off);
      6'd8:          idx = 5'd7;
      [6'd9:6'd18]:  idx = 5'(off - 6'd1);
      6'd19:         idx = 5'd17;
      [6'd20:6'd24]: idx = 5'(off - 6'd2);
      6'd25:         idx = 5'd22;
      [6'd26:6'd30]: idx = 5'(off - 6'd3);
      default:       idx = 5'd0;
    endcase
    return idx;
  endfunction

  // Precomposed syllable, or zero when the parts cannot form one.
  function automatic logic [15:0] syllable(logic [5:0] lead, logic [5:0] vowel,
                                           logic [5:0] tail);
    logic [15:0] l;
    logic [15:0] v;
    logic [15:0] t;
    logic        bad;
    bad = !lead_ok(lead) || (vowel < VOWEL_FIRST) || (vowel > VOWEL_LAST) ||
          ((tail != 6'd0) && !tail_ok(tail));
    l = 16'(lead_index(lead));
    v = 16'(vowel - VOWEL_FIRST);
    t = (tail == 6'd0) ? 16'd0 : 16'(tail_index(tail));
    if (bad) begin
      return 16'd0;
    end
    return SYL_BASE + l * 16'(VOWEL_COUNT * TAIL_COUNT) + v * 16'(TAIL_COUNT) + t;
  endfunction

  // Compound tail from two parts, zero when the pair does not combine.
  function automatic logic [5:0] join_tail(logic [5:0] a, logic [5:0] b);
    logic [5:0] c;
    case ({a, b})
      {6'd1, 6'd21}:  c = 6'd3;
      {6'd4, 6'd24}:  c = 6'd5;
      {6'd4, 6'd30}:  c = 6'd6;
      {6'd9, 6'd1}:   c = 6'd10;
      {6'd9, 6'd17}:  c = 6'd11;
      {6'd9, 6'd18}:  c = 6'd12;
      {6'd9, 6'd21}:  c = 6'd13;
      {6'd9, 6'd28}:  c = 6'd14;
      {6'd9, 6'd29}:  c = 6'd15;
      {6'd9, 6'd30}:  c = 6'd16;
      {6'd18, 6'd21}: c = 6'd20;
      default:        c = 6'd0;
    endcase
    return c;
  endfunction

  // Parts of a compound tail as {found, first, second}.
  function automatic logic [12:0] split_tail(logic [5:0] c);
    logic [12:0] r;
    case (c)
      6'd3:    r = {1'b1, 6'd1, 6'd21};
      6'd5:    r = {1'b1, 6'd4, 6'd24};
      6'd6:    r = {1'b1, 6'd4, 6'd30};
      6'd10:   r = {1'b1, 6'd9, 6'd1};
      6'd11:   r = {1'b1, 6'd9, 6'd17};
      6'd12:   r = {1'b1, 6'd9, 6'd18};
      6'd13:   r = {1'b1, 6'd9, 6'd21};
      6'd14:   r = {1'b1, 6'd9, 6'd28};
      6'd15:   r = {1'b1, 6'd9, 6'd29};
      6'd16:   r = {1'b1, 6'd9, 6'd30};
      6'd20:   r = {1'b1, 6'd18, 6'd21};
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] join_vowel(logic [5:0] a, logic [5:0] b);
    logic [5:0] c;
    case ({a, b})
      {6'd39, 6'd31}: c = 6'd40;
      {6'd39, 6'd32}: c = 6'd41;
      {6'd39, 6'd51}: c = 6'd42;
      {6'd44, 6'd35}: c = 6'd45;
      {6'd44, 6'd36}: c = 6'd46;
      {6'd44, 6'd51}: c = 6'd47;
      {6'd49, 6'd51}: c = 6'd50;
      default:        c = 6'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/hjc_if.sv
// Valid/ready channel interfaces for key items and composed results.
// Depends on nothing; widths follow the block's field list.
interface hjc_key_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [20:0] key_code;

  modport source (output valid, output command, output key_code, input ready);
  modport sink (input valid, input command, input key_code, output ready);
endinterface

interface hjc_result_if;
  logic        valid;
  logic        ready;
  logic        replace_previous;
  logic [1:0]  char_count;
  logic [20:0] first_char;
  logic [15:0] second_char;

  modport source (output valid, output replace_previous, output char_count,
                  output first_char, output second_char, input ready);
  modport sink (input valid, input replace_previous, input char_count,
                input first_char, input second_char, output ready);
endinterface

FILE: src/hangul_jamo_composer.sv
// Top level of the Hangul two-set jamo composer: input register, rule logic, result register.
// Depends on hjc_pkg, hjc_if (hjc_key_if, hjc_result_if) and hjc_step.
//
// Keys arrive one code point per transfer on keys; each key press gives exactly one
// transfer on chars, and a clear command gives none but empties the composition.
// Jamo U+3131..U+3163 are built into precomposed syllables; replace_previous tells the
// caller to delete the character it last received before inserting first_char (and
// second_char when char_count is two, i.e. a vowel pulled the tail onto a new syllable).
// Any other code point passes through and ends composition. Throughput is one key per
// clock while chars.ready stays high; a taken key is loaded into the input register, and
// its result is loaded into the result register once that register is free. The
// composition state is updated in the same cycle the key leaves the input register, so
// the state loop through the rule logic is what sets the rate. keys.ready falls only
// while both the input and the result register are full and chars.ready is low.
module hangul_jamo_composer import hjc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  hjc_key_if.sink            keys,
  hjc_result_if.source       chars
);

  // Input register
  logic        in_valid;
  logic        in_command;
  logic [20:0] in_key_code;

  // Composition state and result register
  hjc_state_t  state;
  hjc_state_t  state_next;
  hjc_result_t step_res;
  logic        step_emit;
  logic        out_valid;
  hjc_result_t out_res;

  logic        out_free;
  logic        advance;

  assign out_free   = !out_valid || chars.ready;
  assign advance    = in_valid && out_free;
  assign keys.ready = !in_valid || out_free;

  hjc_step u_step (
    .cur      (state),
    .command  (in_command),
    .key_code (in_key_code),
    .nxt      (state_next),
    .res      (step_res),
    .emit     (step_emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (keys.valid && keys.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (keys.valid && keys.ready) begin
      in_command  <= keys.command;
      in_key_code <= keys.key_code;
    end
  end

  // State moves on as the key leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_emit) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      out_res <= step_res;
    end
  end

  assign chars.valid            = out_valid;
  assign chars.replace_previous = out_res.replace_previous;
  assign chars.char_count       = out_res.char_count;
  assign chars.first_char       = out_res.first_char;
  assign chars.second_char      = out_res.second_char;

endmodule

FILE: src/hjc_step.sv
// Composition rules for one key: next state and result from current state.
// Depends on hjc_pkg.
module hjc_step import hjc_pkg::*; (
  input  hjc_state_t  cur,
  input  logic        command,
  input  logic [20:0] key_code,
  output hjc_state_t  nxt,
  output hjc_result_t res,
  output logic        emit
);

  logic        is_jamo;
  logic [5:0]  off;
  logic        is_cons;
  logic        is_vowel;
  logic [5:0]  joined_tail;
  logic [5:0]  tail_cand;
  logic [5:0]  joined_vowel;
  logic [5:0]  vowel_cand;
  logic [12:0] split;
  logic [5:0]  split_lead;
  logic [15:0] syl_tail;
  logic [15:0] syl_open;
  logic [15:0] syl_first;
  logic [15:0] syl_second;

  assign is_jamo  = (key_code >= JAMO_FIRST) && (key_code <= JAMO_LAST);
  assign off      = 6'(key_code - JAMO_ORIGIN);
  assign is_cons  = is_jamo && (off <= CONS_LAST) && lead_ok(off);
  assign is_vowel = is_jamo && (off > CONS_LAST);

  // Three syllable builders: tail added, open syllable, tail split.
  assign joined_tail  = join_tail(cur.tail, off);
  assign tail_cand    = (cur.tail == 6'd0) ? off : joined_tail;
  assign syl_tail     = syllable(cur.lead, cur.vowel, tail_cand);

  assign joined_vowel = join_vowel(cur.vowel, off);
  assign vowel_cand   = (cur.vowel == 6'd0) ? off : joined_vowel;
  assign syl_open     = syllable(cur.lead, vowel_cand, 6'd0);

  assign split        = split_tail(cur.tail);
  assign split_lead   = split[12] ? split[5:0] : cur.tail;
  assign syl_first    = syllable(cur.lead, cur.vowel, split[12] ? split[11:6] : 6'd0);
  assign syl_second   = syllable(split_lead, off, 6'd0);

  always_comb begin
    nxt                  = cur;
    res.replace_previous = 1'b0;
    res.char_count       = 2'd1;
    res.first_char       = key_code;
    res.second_char      = 16'd0;
    emit                 = 1'b1;
    if (command == CMD_CLEAR) begin
      nxt  = '0;
      emit = 1'b0;
    end else if (is_cons) begin
      if (!cur.composing || cur.vowel == 6'd0 ||
          (cur.tail != 6'd0 && joined_tail == 6'd0)) begin
        nxt.lead      = off;
        nxt.vowel     = 6'd0;
        nxt.tail      = 6'd0;
        nxt.composing = 1'b1;
      end else begin
        nxt.tail = tail_cand;
        if (syl_tail != 16'd0) begin
          res.replace_previous = 1'b1;
          res.first_char       = 21'(syl_tail);
        end else begin
          nxt.composing = 1'b0;
        end
      end
    end else if (is_vowel) begin
      if (!cur.composing || cur.lead == 6'd0) begin
        nxt.composing = 1'b0;
      end else if (cur.vowel != 6'd0 && cur.tail != 6'd0) begin
        res.replace_previous = 1'b1;
        res.char_count       = 2'd2;
        res.first_char       = 21'(syl_first);
        res.second_char      = syl_second;
        nxt.lead             = split_lead;
        nxt.vowel            = off;
        nxt.tail             = 6'd0;
      end else if (vowel_cand != 6'd0) begin
        nxt.vowel = vowel_cand;
        if (syl_open != 16'd0) begin
          res.replace_previous = 1'b1;
          res.first_char       = 21'(syl_open);
        end else begin
          nxt.composing = 1'b0;
        end
      end else begin
        nxt.composing = 1'b0;
      end
    end else begin
      nxt.composing = 1'b0;
    end
  end

endmodule
